// File: hdl/pci_config_space_access_top_defines.svh
// assertion macros for the configuration access block
`ifndef PCI_CONFIG_SPACE_ACCESS_TOP_DEFINES_SVH
`define PCI_CONFIG_SPACE_ACCESS_TOP_DEFINES_SVH

// clocked assertion, masked while reset is asserted
`define PCSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define PCSA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/pcsa_pkg.sv
// shared types, codes and helper functions for the configuration access block
package pcsa_pkg;

  localparam int SLOT_W = 5;
  localparam int WORD_W = 6;
  localparam int LIN_W  = 11;

  localparam logic [1:0] OP_ADDR  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  localparam logic [31:0] PRESENT_RESET = 32'h0000_4800;
  localparam logic [31:0] NO_DEVICE     = 32'hFFFF_FFFF;

  typedef struct packed {
    logic hit;    // enabled, decodable and present target
    logic wr_ok;  // hit and not a read-only word
  } dec_t;

  function automatic logic [31:0] byte_rev(input logic [31:0] v);
    byte_rev = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  // reset contents of the store, zero where no device word is preset
  function automatic logic [31:0] preset_word(input logic [SLOT_W-1:0] slot,
                                              input logic [WORD_W-1:0] word);
    logic [31:0] v;
    v = 32'h0;
    if (slot == 5'd14) begin
      case (word)
        6'd0:    v = 32'h0001_1000;
        6'd1:    v = 32'h0280_0006;
        6'd2:    v = 32'h0100_0001;
        6'd4:    v = 32'hC000_0001;
        6'd5:    v = 32'hC100_0000;
        6'd15:   v = 32'h0000_0100;
        default: v = 32'h0;
      endcase
    end else if (slot == 5'd11) begin
      case (word)
        6'd0:    v = 32'h1786_11DB;
        6'd1:    v = 32'h0280_0000;
        6'd2:    v = 32'h0300_0001;
        default: v = 32'h0;
      endcase
    end
    preset_word = v;
  endfunction

endpackage

// File: hdl/pcsa_decode.sv
// decode of the latched config address into a hit flag and a store address
module pcsa_decode #(
  parameter int DEVICE_SLOTS     = 32,
  parameter int WORDS_PER_DEVICE = 64,
  parameter int ADDR_W           = 11
) (
  input  logic [31:0]       latch,
  input  logic [31:0]       present_mask,
  output pcsa_pkg::dec_t    dec,
  output logic [ADDR_W-1:0] addr
);
  import pcsa_pkg::*;

  localparam logic [SLOT_W:0] SLOTS_L = (SLOT_W + 1)'(DEVICE_SLOTS);
  localparam logic [WORD_W:0] WORDS_L = (WORD_W + 1)'(WORDS_PER_DEVICE);

  logic [SLOT_W-1:0] slot;
  logic [WORD_W-1:0] word;
  logic [LIN_W-1:0]  lin;
  logic              hit;

  assign slot = latch[15:11];
  assign word = latch[7:2];

  assign hit = latch[31] && (latch[23:16] == 8'h00) && (latch[10:8] == 3'd0) &&
               ({1'b0, slot} < SLOTS_L) && present_mask[slot] &&
               ({1'b0, word} < WORDS_L);

  assign dec.hit   = hit;
  // ids and class words are read-only
  assign dec.wr_ok = hit && (word != 6'd0) && (word != 6'd2);

  assign lin  = LIN_W'(slot) * LIN_W'(WORDS_PER_DEVICE) + LIN_W'(word);
  assign addr = lin[ADDR_W-1:0];

endmodule

// File: hdl/pcsa_store.sv
// config word memory with the post-reset clear and preload sweep
module pcsa_store #(
  parameter int DEVICE_SLOTS     = 32,
  parameter int WORDS_PER_DEVICE = 64,
  parameter int ADDR_W           = 11
) (
  input  logic              clk,
  input  logic              rst_n,
  output logic              clearing,
  input  logic              wr_en,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] addr,
  input  logic [31:0]       wdata,
  output logic [31:0]       rdata
);
  import pcsa_pkg::*;

  localparam int DEPTH = DEVICE_SLOTS * WORDS_PER_DEVICE;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(DEVICE_SLOTS - 1);
  localparam logic [WORD_W-1:0] WORD_LAST = WORD_W'(WORDS_PER_DEVICE - 1);

  logic [31:0]       mem [DEPTH];
  logic [31:0]       rdata_r;
  logic              clearing_r, clearing_nxt;
  logic [SLOT_W-1:0] clr_slot_r, clr_slot_nxt;
  logic [WORD_W-1:0] clr_word_r, clr_word_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [31:0]       mem_wdata;

  always_comb begin
    clr_slot_nxt = clr_slot_r;
    clr_word_nxt = clr_word_r;
    clr_addr_nxt = clr_addr_r;
    clearing_nxt = clearing_r;
    if (clearing_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_word_r == WORD_LAST) begin
        clr_word_nxt = '0;
        clr_slot_nxt = clr_slot_r + 1'b1;
        if (clr_slot_r == SLOT_LAST) begin
          clearing_nxt = 1'b0;
        end
      end else begin
        clr_word_nxt = clr_word_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_slot_r <= '0;
      clr_word_r <= '0;
      clr_addr_r <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_slot_r <= clr_slot_nxt;
      clr_word_r <= clr_word_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // the sweep owns the write port until it is done
  assign mem_we    = clearing_r || wr_en;
  assign mem_waddr = clearing_r ? clr_addr_r : addr;
  assign mem_wdata = clearing_r ? preset_word(clr_slot_r, clr_word_r) : wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  assign clearing = clearing_r;
  assign rdata    = rdata_r;

endmodule

// File: hdl/pci_config_space_access_top.sv
// top level of the config mechanism access block behind a byte-reversing bridge
// an item is registered in the input register, then decoded and the store accessed
// from there; a read result is registered in the store's read register
// throughput: one item per cycle; a read waits in the input register while the
// result register is full and not taken
// reset: after rst_n the store is cleared and preloaded one word a cycle,
// over all DEVICE_SLOTS * WORDS_PER_DEVICE words (2048 by default), with in_ready low
`include "pci_config_space_access_top_defines.svh"
module pci_config_space_access_top #(
  parameter int DEVICE_SLOTS     = 32,
  parameter int WORDS_PER_DEVICE = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_bus_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_data
);
  import pcsa_pkg::*;

  localparam int ADDR_W = $clog2(DEVICE_SLOTS * WORDS_PER_DEVICE);

  logic [31:0]       present_mask_r;
  logic [31:0]       latch_r;
  logic              s1_valid_r, s1_valid_nxt;
  logic [1:0]        s1_op_r;
  logic [31:0]       s1_data_r;
  logic              out_valid_r, out_valid_nxt;
  logic              hit_r;
  logic              s1_adv;
  logic              s1_rd;
  logic              in_acc;
  logic              clearing;
  dec_t              dec;
  logic [ADDR_W-1:0] addr;
  logic [31:0]       rdata;

  pcsa_decode #(
    .DEVICE_SLOTS     (DEVICE_SLOTS),
    .WORDS_PER_DEVICE (WORDS_PER_DEVICE),
    .ADDR_W           (ADDR_W)
  ) u_decode (
    .latch        (latch_r),
    .present_mask (present_mask_r),
    .dec          (dec),
    .addr         (addr)
  );

  pcsa_store #(
    .DEVICE_SLOTS     (DEVICE_SLOTS),
    .WORDS_PER_DEVICE (WORDS_PER_DEVICE),
    .ADDR_W           (ADDR_W)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .clearing (clearing),
    .wr_en    (s1_adv && (s1_op_r == OP_WRITE) && dec.wr_ok),
    .rd_en    (s1_rd),
    .addr     (addr),
    .wdata    (byte_rev(s1_data_r)),
    .rdata    (rdata)
  );

  // only a read needs room in the result register
  assign s1_adv   = s1_valid_r && ((s1_op_r != OP_READ) || !out_valid_r || out_ready);
  assign s1_rd    = s1_adv && (s1_op_r == OP_READ);
  assign in_ready = !clearing && (!s1_valid_r || s1_adv);
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_rd) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_mask_r <= PRESENT_RESET;
      latch_r        <= '0;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        present_mask_r <= cfg_wdata;
      end
      if (s1_adv) begin
        case (s1_op_r)
          OP_ADDR: latch_r <= byte_rev(s1_data_r);
          default: latch_r <= latch_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r   <= in_op;
      s1_data_r <= in_bus_data;
    end
    if (s1_rd) begin
      hit_r <= dec.hit;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = byte_rev(hit_r ? rdata : NO_DEVICE);

  `PCSA_ASSERT(a_no_accept_clearing, clearing |-> !in_ready, "item taken during clear sweep")
  `PCSA_ASSERT(a_read_gives_result, s1_rd |=> out_valid, "read item produced no result")
  `PCSA_ASSERT_ALWAYS(a_stage_empty_clearing, clearing |-> !s1_valid_r,
                      "item in flight during clear sweep")

endmodule

// File: verif/tb_pci_config_space_access_top.sv
// testbench for the byte-reversed pci configuration access block
`timescale 1ns / 100ps

module tb_pci_config_space_access_top;
  import pcsa_pkg::*;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_AT_ITEM  = 150;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 6;
  localparam int TAIL_CYCLES   = 8;

  // expected behavior of the config space, fed with every accepted item
  class cfg_space_scoreboard;
    localparam int SLOTS       = 32;
    localparam int SLOT_WORDS  = 64;
    localparam int WORD_IDS    = 0;
    localparam int WORD_CLASS  = 2;
    localparam int MAX_REPORTS = 10;

    logic [31:0] present_slots;
    logic [31:0] addr_latch;
    logic [31:0] cfg_words [SLOTS*SLOT_WORDS];
    logic [31:0] pending_reads [$];
    int mismatches;
    int items_noted;
    int reads_checked;
    int reads_absent;
    int writes_stored;

    function new();
      present_slots = PRESENT_RESET;
      addr_latch    = '0;
      foreach (cfg_words[i]) cfg_words[i] = '0;
      cfg_words[14*SLOT_WORDS + 0]  = 32'h0001_1000;
      cfg_words[14*SLOT_WORDS + 1]  = 32'h0280_0006;
      cfg_words[14*SLOT_WORDS + 2]  = 32'h0100_0001;
      cfg_words[14*SLOT_WORDS + 4]  = 32'hC000_0001;
      cfg_words[14*SLOT_WORDS + 5]  = 32'hC100_0000;
      cfg_words[14*SLOT_WORDS + 15] = 32'h0000_0100;
      cfg_words[11*SLOT_WORDS + 0]  = 32'h1786_11DB;
      cfg_words[11*SLOT_WORDS + 1]  = 32'h0280_0000;
      cfg_words[11*SLOT_WORDS + 2]  = 32'h0300_0001;
      mismatches    = 0;
      items_noted   = 0;
      reads_checked = 0;
      reads_absent  = 0;
      writes_stored = 0;
    endfunction

    static function logic [31:0] wire_swap(logic [31:0] v);
      return {<<8{v}};
    endfunction

    function void set_present(logic [31:0] mask);
      present_slots = mask;
    endfunction

    function int pending();
      return pending_reads.size();
    endfunction

    // decode the latched address; true on an enabled, present bus 0 function 0 target
    function bit locate(output int idx, output int word);
      int slot;
      slot = int'(addr_latch[15:11]);
      word = int'(addr_latch[7:2]);
      idx  = slot * SLOT_WORDS + word;
      return addr_latch[31] && addr_latch[23:16] == 8'd0 && addr_latch[10:8] == 3'd0 &&
             slot < SLOTS && present_slots[slot] && word < SLOT_WORDS;
    endfunction

    function void note_item(logic [1:0] op, logic [31:0] bus_data);
      int idx;
      int word;
      bit hit;
      items_noted++;
      case (op)
        pcsa_pkg::OP_ADDR: addr_latch = wire_swap(bus_data);
        pcsa_pkg::OP_READ: begin
          hit = locate(idx, word);
          pending_reads.push_back(wire_swap(hit ? cfg_words[idx] : pcsa_pkg::NO_DEVICE));
          if (!hit) reads_absent++;
        end
        pcsa_pkg::OP_WRITE: begin
          if (locate(idx, word) && word != WORD_IDS && word != WORD_CLASS) begin
            cfg_words[idx] = wire_swap(bus_data);
            writes_stored++;
          end
        end
        default: ;
      endcase
    endfunction

    function void flag(string what, logic [31:0] exp_val, logic [31:0] got_val);
      if (mismatches < MAX_REPORTS)
        $display("mismatch: %s expected %08h got %08h", what, exp_val, got_val);
      mismatches++;
    endfunction

    function void check_read(logic [31:0] got);
      logic [31:0] exp_val;
      if (pending_reads.size() == 0) begin
        flag("unexpected read result,", 32'hx, got);
      end else begin
        exp_val = pending_reads.pop_front();
        reads_checked++;
        if (got !== exp_val) flag("read_data", exp_val, got);
      end
    endfunction

    function void final_check();
      while (pending_reads.size() != 0) flag("missing read result,", pending_reads.pop_front(), 32'hx);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_op;
  logic [31:0] in_bus_data;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_read_data;

  cfg_space_scoreboard sb;
  int tx_idle_pct;
  int rx_idle_pct;
  int items_in;
  int cycles;
  int mask_settings;

  pci_config_space_access_top u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_op        (in_op),
    .in_bus_data  (in_bus_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_read_data(out_read_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // handshakes seen at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_read(out_read_data);
      if (in_valid && in_ready) begin
        sb.note_item(in_op, in_bus_data);
        items_in++;
      end
    end
  end

  // result side: random stalls, plus one long hold-off so the block backs up
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && items_in >= HOLD_AT_ITEM) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [31:0] target_word(bit en, logic [7:0] bus_no, logic [4:0] slot,
                                               logic [2:0] fn, logic [5:0] word);
    return cfg_space_scoreboard::wire_swap({en, 7'd0, bus_no, slot, fn, word, 2'b00});
  endfunction

  // mostly good targets on bus 0, now and then a disabled or undecodable one
  function automatic logic [31:0] random_target();
    logic [31:0] a;
    a = $urandom();
    a[31]    = 1'b1;
    a[23:16] = 8'd0;
    a[10:8]  = 3'd0;
    if ($urandom_range(1)) a[15:11] = $urandom_range(1) ? 5'd11 : 5'd14;
    if ($urandom_range(2) == 0) begin
      case ($urandom_range(3))
        0:       a[7:2] = 6'd0;
        1:       a[7:2] = 6'd2;
        2:       a[7:2] = 6'd15;
        default: a[7:2] = 6'd63;
      endcase
    end
    case ($urandom_range(19))
      0:       a[31] = 1'b0;
      1:       a[23:16] = 8'($urandom_range(255, 1));
      2:       a[10:8] = 3'($urandom_range(7, 1));
      default: ;
    endcase
    return cfg_space_scoreboard::wire_swap(a);
  endfunction

  // entered and left at a falling edge
  task automatic send_item(input logic [1:0] op, input logic [31:0] data);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_bus_data <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // writes still in the pipe produce nothing, so wait out the latency too
  task automatic write_mask(input logic [31:0] mask);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mask;
    sb.set_present(mask);
    mask_settings++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_accesses(input int count, input bit pause_midway);
    int          sent;
    int          n;
    bit          paused;
    logic [1:0]  op;
    sent   = 0;
    paused = 1'b0;
    while (sent < count) begin
      if (pause_midway && !paused && sent >= count / 2) begin
        drain();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 80) begin
        send_item(OP_ADDR, random_target());
        sent++;
        n = $urandom_range(4, 1);
        repeat (n) begin
          send_item($urandom_range(1) ? OP_READ : OP_WRITE, $urandom());
          sent++;
        end
      end else begin
        op = 2'($urandom_range(3));
        send_item(op, $urandom());
        if (op != OP_UNUSED) sent++;
      end
    end
  endtask

  initial begin
    sb            = new();
    items_in      = 0;
    mask_settings = 1;
    tx_idle_pct   = 34;
    rx_idle_pct   = 71;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_op         = OP_ADDR;
    in_bus_data   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part with the reset present mask
    send_item(OP_READ, 32'h0000_0000);
    send_item(OP_ADDR, target_word(1'b1, 8'd0, 5'd14, 3'd0, 6'd0));
    send_item(OP_READ, 32'hFFFF_FFFF);
    send_item(OP_ADDR, target_word(1'b1, 8'd0, 5'd14, 3'd0, 6'd15));
    send_item(OP_READ, 32'h0000_0000);
    send_item(OP_ADDR, target_word(1'b1, 8'd0, 5'd11, 3'd0, 6'd2));
    send_item(OP_WRITE, 32'hFFFF_FFFF);
    send_item(OP_READ, 32'h0000_0000);
    send_item(OP_ADDR, target_word(1'b1, 8'd0, 5'd14, 3'd0, 6'd0));
    send_item(OP_WRITE, 32'h0000_0000);
    send_item(OP_READ, 32'h0000_0000);
    send_item(OP_ADDR, target_word(1'b1, 8'd0, 5'd14, 3'd0, 6'd63));
    send_item(OP_WRITE, 32'hFFFF_FFFF);
    send_item(OP_READ, 32'h0000_0000);
    send_item(OP_WRITE, 32'h1234_5678);
    send_item(OP_READ, 32'h0000_0000);
    send_item(OP_ADDR, target_word(1'b1, 8'hFF, 5'd14, 3'd0, 6'd1));
    send_item(OP_WRITE, 32'hFFFF_FFFF);
    send_item(OP_READ, 32'h0000_0000);
    send_item(OP_ADDR, target_word(1'b1, 8'd0, 5'd14, 3'd7, 6'd1));
    send_item(OP_READ, 32'h0000_0000);
    send_item(OP_ADDR, target_word(1'b1, 8'd0, 5'd31, 3'd0, 6'd0));
    send_item(OP_READ, 32'h0000_0000);
    send_item(OP_ADDR, target_word(1'b0, 8'd0, 5'd14, 3'd0, 6'd1));
    send_item(OP_WRITE, 32'hAAAA_5555);
    send_item(OP_READ, 32'h0000_0000);
    send_item(OP_UNUSED, 32'hFFFF_FFFF);

    // every slot present; the receiver hold-off lands in this stretch
    write_mask(32'hFFFF_FFFF);
    random_accesses(320, 1'b0);

    write_mask($urandom() | PRESENT_RESET);
    tx_idle_pct = 71;
    rx_idle_pct = 34;
    random_accesses(320, 1'b1);

    write_mask(32'h0000_0000);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_accesses(60, 1'b0);

    write_mask(PRESENT_RESET);
    random_accesses(230, 1'b0);

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    sb.final_check();
    $display("covered %0d accesses over %0d present-mask settings, including a long result stall",
             sb.items_noted, mask_settings);
    $display("%0d reads checked (%0d with no device answering), %0d writes stored",
             sb.reads_checked, sb.reads_absent, sb.writes_stored);
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/pcsa_pkg.sv
hdl/pcsa_decode.sv
hdl/pcsa_store.sv
hdl/pci_config_space_access_top.sv
verif/tb_pci_config_space_access_top.sv
